FILE: hdl/ps2h_pkg.sv
// Package: shared types, codes and reset constants for the PS/2 host transceiver.
`timescale 1ns / 1ps

package ps2h_pkg;

	localparam int DELAY_WIDTH_DEF = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [CFG_DATA_W-1:0] IDLE_RELEASE_RST   = 16'd300;
	localparam logic [CFG_DATA_W-1:0] INHIBIT_RST        = 16'd300;
	localparam logic [CFG_DATA_W-1:0] DATA_LEAD_RST      = 16'd10;
	localparam logic [CFG_DATA_W-1:0] LISTEN_RELEASE_RST = 16'd50;
	localparam logic [CFG_DATA_W-1:0] START_SETTLE_RST   = 16'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RELEASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_LEAD      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_RELEASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SETTLE   = 3'd4;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SEND = 2'd1;
	localparam logic [1:0] KIND_RECV = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [4:0] {
		P_IDLE_REL, P_IDLE_INH,
		P_S_REL, P_S_INH, P_S_LEAD, P_S_W0, P_S_BL, P_S_BH, P_S_PL, P_S_PH,
		P_S_ACKD, P_S_AW1, P_S_AW2,
		P_R_REL, P_R_WS, P_R_SET, P_R_WSH, P_R_BL, P_R_BH,
		P_R_T1, P_R_T2, P_R_T3, P_R_T4
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       clk_in;
		logic       data_in;
	} cmd_t;

	typedef struct packed {
		logic       clk_pull_low;
		logic       data_pull_low;
		logic       busy_res;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       tx_done;
	} res_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] idle_release_ticks;
		logic [CFG_DATA_W-1:0] inhibit_ticks;
		logic [CFG_DATA_W-1:0] data_lead_ticks;
		logic [CFG_DATA_W-1:0] listen_release_ticks;
		logic [CFG_DATA_W-1:0] start_settle_ticks;
	} cfg_regs_t;

endpackage

FILE: hdl/ps2h_if.sv
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps

interface ps2h_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic       clk_in;
	logic       data_in;

	modport source (output valid, kind, tx_byte, clk_in, data_in, input ready);
	modport sink   (input valid, kind, tx_byte, clk_in, data_in, output ready);
endinterface

interface ps2h_res_if;
	logic       valid;
	logic       ready;
	logic       clk_pull_low;
	logic       data_pull_low;
	logic       busy_res;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic       tx_done;

	modport source (output valid, clk_pull_low, data_pull_low, busy_res, rx_valid, rx_byte,
		tx_done, input ready);
	modport sink   (input valid, clk_pull_low, data_pull_low, busy_res, rx_valid, rx_byte,
		tx_done, output ready);
endinterface

interface ps2h_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ps2h_cfg_regs.sv
// Configuration register bank for the tick delays.
`timescale 1ns / 1ps

module ps2h_cfg_regs
	import ps2h_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.idle_release_ticks   <= IDLE_RELEASE_RST;
			regs_q.inhibit_ticks        <= INHIBIT_RST;
			regs_q.data_lead_ticks      <= DATA_LEAD_RST;
			regs_q.listen_release_ticks <= LISTEN_RELEASE_RST;
			regs_q.start_settle_ticks   <= START_SETTLE_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_IDLE_RELEASE:   regs_q.idle_release_ticks   <= wr_data;
				CFG_INHIBIT:        regs_q.inhibit_ticks        <= wr_data;
				CFG_DATA_LEAD:      regs_q.data_lead_ticks      <= wr_data;
				CFG_LISTEN_RELEASE: regs_q.listen_release_ticks <= wr_data;
				CFG_START_SETTLE:   regs_q.start_settle_ticks   <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

FILE: hdl/ps2h_core.sv
// Line sequencer: state registers and per-tick next-state logic.
`timescale 1ns / 1ps

module ps2h_core
	import ps2h_pkg::*;
#(
	parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  cmd_t      cmd_s1,
	input  cfg_regs_t regs,
	output res_t      res
);

	phase_t                 phase_q, phase_n;
	logic [3:0]             bit_count_q, bit_count_n, bit_count_inc;
	logic [7:0]             shift_q, shift_n, shift_sr;
	logic                   parity_q, parity_n, parity_x;
	logic [DELAY_WIDTH-1:0] delay_q, delay_n, delay_dec;
	logic                   delay_zero;
	logic                   clk_drive_q, clk_drive_n;
	logic                   data_drive_q, data_drive_n;
	logic [7:0]             last_rx_q, last_rx_n;
	logic                   rxv, txd;

	assign delay_zero    = (delay_q == '0);
	assign delay_dec     = delay_q - DELAY_WIDTH'(1);
	assign bit_count_inc = bit_count_q + 4'd1;
	assign shift_sr      = {1'b0, shift_q[7:1]};
	assign parity_x      = parity_q ^ shift_q[0];

	// next state
	always_comb begin
		phase_n      = phase_q;
		bit_count_n  = bit_count_q;
		shift_n      = shift_q;
		parity_n     = parity_q;
		delay_n      = delay_q;
		clk_drive_n  = clk_drive_q;
		data_drive_n = data_drive_q;
		last_rx_n    = last_rx_q;
		rxv          = 1'b0;
		txd          = 1'b0;
		case (phase_q)
			P_IDLE_REL, P_IDLE_INH: begin
				if (cmd_s1.kind == KIND_SEND) begin
					clk_drive_n  = 1'b0;
					data_drive_n = 1'b0;
					shift_n      = cmd_s1.tx_byte;
					parity_n     = 1'b1;
					bit_count_n  = '0;
					delay_n      = DELAY_WIDTH'(regs.idle_release_ticks);
					phase_n      = P_S_REL;
				end else if (cmd_s1.kind == KIND_RECV) begin
					clk_drive_n  = 1'b0;
					data_drive_n = 1'b0;
					shift_n      = '0;
					bit_count_n  = '0;
					delay_n      = DELAY_WIDTH'(regs.listen_release_ticks);
					phase_n      = P_R_REL;
				end
			end
			P_S_REL: begin
				if (delay_zero) begin
					clk_drive_n = 1'b1;
					delay_n     = DELAY_WIDTH'(regs.inhibit_ticks);
					phase_n     = P_S_INH;
				end else delay_n = delay_dec;
			end
			P_S_INH: begin
				if (delay_zero) begin
					data_drive_n = 1'b1;
					delay_n      = DELAY_WIDTH'(regs.data_lead_ticks);
					phase_n      = P_S_LEAD;
				end else delay_n = delay_dec;
			end
			P_S_LEAD: begin
				if (delay_zero) begin
					clk_drive_n = 1'b0;
					phase_n     = P_S_W0;
				end else delay_n = delay_dec;
			end
			P_S_W0: begin
				if (!cmd_s1.clk_in) begin
					data_drive_n = ~shift_q[0];
					phase_n      = P_S_BL;
				end
			end
			P_S_BL: begin
				if (cmd_s1.clk_in) phase_n = P_S_BH;
			end
			P_S_BH: begin
				if (!cmd_s1.clk_in) begin
					parity_n    = parity_x;
					shift_n     = shift_sr;
					bit_count_n = bit_count_inc;
					if (bit_count_inc < BITS_PER_BYTE) begin
						data_drive_n = ~shift_sr[0];
						phase_n      = P_S_BL;
					end else begin
						data_drive_n = ~parity_x;
						phase_n      = P_S_PL;
					end
				end
			end
			P_S_PL: begin
				if (cmd_s1.clk_in) phase_n = P_S_PH;
			end
			P_S_PH: begin
				if (!cmd_s1.clk_in) begin
					data_drive_n = 1'b0;
					delay_n      = DELAY_WIDTH'(regs.listen_release_ticks);
					phase_n      = P_S_ACKD;
				end
			end
			P_S_ACKD: begin
				if (delay_zero) phase_n = P_S_AW1;
				else delay_n = delay_dec;
			end
			P_S_AW1: begin
				if (!cmd_s1.clk_in) phase_n = P_S_AW2;
			end
			P_S_AW2: begin
				if (cmd_s1.clk_in && cmd_s1.data_in) begin
					clk_drive_n = 1'b1;
					txd         = 1'b1;
					phase_n     = P_IDLE_INH;
				end
			end
			P_R_REL: begin
				if (delay_zero) phase_n = P_R_WS;
				else delay_n = delay_dec;
			end
			P_R_WS: begin
				if (!cmd_s1.clk_in) begin
					delay_n = DELAY_WIDTH'(regs.start_settle_ticks);
					phase_n = P_R_SET;
				end
			end
			P_R_SET: begin
				if (delay_zero) phase_n = P_R_WSH;
				else delay_n = delay_dec;
			end
			P_R_WSH: begin
				if (cmd_s1.clk_in) phase_n = P_R_BL;
			end
			P_R_BL: begin
				if (!cmd_s1.clk_in) begin
					if (cmd_s1.data_in) shift_n[bit_count_q[2:0]] = 1'b1;
					phase_n = P_R_BH;
				end
			end
			P_R_BH: begin
				if (cmd_s1.clk_in) begin
					bit_count_n = bit_count_inc;
					phase_n     = (bit_count_inc < BITS_PER_BYTE) ? P_R_BL : P_R_T1;
				end
			end
			P_R_T1: begin
				if (!cmd_s1.clk_in) phase_n = P_R_T2;
			end
			P_R_T2: begin
				if (cmd_s1.clk_in) phase_n = P_R_T3;
			end
			P_R_T3: begin
				if (!cmd_s1.clk_in) phase_n = P_R_T4;
			end
			P_R_T4: begin
				if (cmd_s1.clk_in) begin
					clk_drive_n = 1'b1;
					last_rx_n   = shift_q;
					rxv         = 1'b1;
					phase_n     = P_IDLE_INH;
				end
			end
			default: begin
				phase_n      = P_IDLE_REL;
				clk_drive_n  = 1'b0;
				data_drive_n = 1'b0;
			end
		endcase
	end

	// outputs reflect the state after this tick
	always_comb begin
		res.clk_pull_low  = clk_drive_n;
		res.data_pull_low = data_drive_n;
		res.busy_res      = (phase_n != P_IDLE_REL) && (phase_n != P_IDLE_INH);
		res.rx_valid      = rxv;
		res.rx_byte       = last_rx_n;
		res.tx_done       = txd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= P_IDLE_REL;
			bit_count_q  <= '0;
			shift_q      <= '0;
			parity_q     <= 1'b1;
			delay_q      <= '0;
			clk_drive_q  <= 1'b0;
			data_drive_q <= 1'b0;
			last_rx_q    <= '0;
		end else if (step) begin
			phase_q      <= phase_n;
			bit_count_q  <= bit_count_n;
			shift_q      <= shift_n;
			parity_q     <= parity_n;
			delay_q      <= delay_n;
			clk_drive_q  <= clk_drive_n;
			data_drive_q <= data_drive_n;
			last_rx_q    <= last_rx_n;
		end
	end

	a_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.rx_valid && res.tx_done))
		else $error("rx_valid and tx_done in the same tick");

	a_tx_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.tx_done |=> phase_q == P_IDLE_INH && clk_drive_q)
		else $error("send completion did not return to clock inhibit");

	a_rx_latched: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.rx_valid |=> last_rx_q == $past(shift_q) && phase_q == P_IDLE_INH)
		else $error("received byte not latched on completion");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(delay_q) && $stable(shift_q))
		else $error("sequencer state moved without a tick");

endmodule

FILE: hdl/ps2_host_transceiver.sv
// PS/2 host transceiver: top level with input stage and result register.
// Path: a command passes through the input register, then the result register
//   fed by the line sequencer.
// Throughput: one tick per cycle when not stalled; one sequencer step per tick.
// Back-pressure on the result channel stalls both stages; no tick is dropped.
// Reset (arst_n low, asynchronous): both lines released, idle, delays and config
//   registers at their defaults, pipeline empty.
`timescale 1ns / 1ps

module ps2_host_transceiver
	import ps2h_pkg::*;
#(
	parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ps2h_cmd_if.sink    cmd,
	ps2h_res_if.source  res,
	ps2h_cfg_if.sink    cfg
);

	cfg_regs_t regs;
	cmd_t      cmd_s1;
	logic      valid_s1;
	res_t      res_next;
	res_t      res_q;
	logic      res_valid_q;
	logic      advance;
	logic      step;

	assign cfg.ready = 1'b1;

	ps2h_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs)
	);

	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.kind    <= cmd.kind;
			cmd_s1.tx_byte <= cmd.tx_byte;
			cmd_s1.clk_in  <= cmd.clk_in;
			cmd_s1.data_in <= cmd.data_in;
		end
	end

	ps2h_core #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd_s1 (cmd_s1),
		.regs   (regs),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res_next;
	end

	assign res.valid         = res_valid_q;
	assign res.clk_pull_low  = res_q.clk_pull_low;
	assign res.data_pull_low = res_q.data_pull_low;
	assign res.busy_res      = res_q.busy_res;
	assign res.rx_valid      = res_q.rx_valid;
	assign res.rx_byte       = res_q.rx_byte;
	assign res.tx_done       = res_q.tx_done;

endmodule

FILE: bench/ps2_host_transceiver_tb.sv
// Testbench: drives PS/2 line ticks through the host transceiver and checks every result tick.
`timescale 1ns / 1ps

module ps2_host_transceiver_tb;
	import ps2h_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [CFG_DATA_W-1:0] TICKS_MAX = 16'hFFFF;
	localparam int RANDOM_TICKS = 300;
	localparam int RANDOM_XFERS = 6;

	typedef enum {LINE_RANDOM, LINE_LOW, LINE_HIGH} line_mode_t;

	logic clk;
	logic arst_n;

	ps2h_cmd_if cmd();
	ps2h_res_if res();
	ps2h_cfg_if cfg();

	ps2_host_transceiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.cfg(cfg)
	);

	// host sequencer model
	phase_t seq_phase;
	logic [3:0] seq_bits;
	logic [7:0] seq_shift;
	logic seq_par;
	logic [DELAY_WIDTH_DEF-1:0] seq_delay;
	logic seq_clk_low;
	logic seq_dat_low;
	logic [7:0] seq_rx_last;
	cfg_regs_t seq_regs;

	res_t tick_res_q[$];

	// emulated device lines
	logic dev_clk;
	logic dev_dat;
	int dev_half;
	line_mode_t dev_mode;

	bit idle_en;
	int ready_hold;
	int n_errors;
	int n_items;
	int n_checked;
	int n_sent;
	int n_recv;
	int n_writes;
	int n_xfers;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(30_000_000);
		$display("timeout: %0d results still pending", tick_res_q.size());
		$display("simulation failed");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic seq_reset();
		seq_phase = P_IDLE_REL;
		seq_bits = '0;
		seq_shift = '0;
		seq_par = 1'b1;
		seq_delay = '0;
		seq_clk_low = 1'b0;
		seq_dat_low = 1'b0;
		seq_rx_last = '0;
		seq_regs.idle_release_ticks = IDLE_RELEASE_RST;
		seq_regs.inhibit_ticks = INHIBIT_RST;
		seq_regs.data_lead_ticks = DATA_LEAD_RST;
		seq_regs.listen_release_ticks = LISTEN_RELEASE_RST;
		seq_regs.start_settle_ticks = START_SETTLE_RST;
	endtask

	function automatic logic seq_busy();
		return seq_phase != P_IDLE_REL && seq_phase != P_IDLE_INH;
	endfunction

	// true once the delay has run out, else counts it down
	function automatic logic delay_expired();
		if (seq_delay == '0)
			return 1'b1;
		seq_delay = seq_delay - 1'b1;
		return 1'b0;
	endfunction

	task automatic seq_step(input cmd_t c, output res_t r);
		logic rxv;
		logic txd;
		rxv = 1'b0;
		txd = 1'b0;
		case (seq_phase)
			P_IDLE_REL, P_IDLE_INH: begin
				if (c.kind == KIND_SEND) begin
					seq_clk_low = 1'b0;
					seq_dat_low = 1'b0;
					seq_shift = c.tx_byte;
					seq_par = 1'b1;
					seq_bits = '0;
					seq_delay = seq_regs.idle_release_ticks;
					seq_phase = P_S_REL;
				end else if (c.kind == KIND_RECV) begin
					seq_clk_low = 1'b0;
					seq_dat_low = 1'b0;
					seq_shift = '0;
					seq_bits = '0;
					seq_delay = seq_regs.listen_release_ticks;
					seq_phase = P_R_REL;
				end
			end
			P_S_REL: if (delay_expired()) begin
				seq_clk_low = 1'b1;
				seq_delay = seq_regs.inhibit_ticks;
				seq_phase = P_S_INH;
			end
			P_S_INH: if (delay_expired()) begin
				seq_dat_low = 1'b1;
				seq_delay = seq_regs.data_lead_ticks;
				seq_phase = P_S_LEAD;
			end
			P_S_LEAD: if (delay_expired()) begin
				seq_clk_low = 1'b0;
				seq_phase = P_S_W0;
			end
			P_S_W0: if (!c.clk_in) begin
				seq_dat_low = ~seq_shift[0];
				seq_phase = P_S_BL;
			end
			P_S_BL: if (c.clk_in) seq_phase = P_S_BH;
			P_S_BH: if (!c.clk_in) begin
				seq_par = seq_par ^ seq_shift[0];
				seq_shift = seq_shift >> 1;
				seq_bits = seq_bits + 1'b1;
				if (seq_bits < BITS_PER_BYTE) begin
					seq_dat_low = ~seq_shift[0];
					seq_phase = P_S_BL;
				end else begin
					seq_dat_low = ~seq_par;
					seq_phase = P_S_PL;
				end
			end
			P_S_PL: if (c.clk_in) seq_phase = P_S_PH;
			P_S_PH: if (!c.clk_in) begin
				seq_dat_low = 1'b0;
				seq_delay = seq_regs.listen_release_ticks;
				seq_phase = P_S_ACKD;
			end
			P_S_ACKD: if (delay_expired()) seq_phase = P_S_AW1;
			P_S_AW1: if (!c.clk_in) seq_phase = P_S_AW2;
			P_S_AW2: if (c.clk_in && c.data_in) begin
				seq_clk_low = 1'b1;
				txd = 1'b1;
				seq_phase = P_IDLE_INH;
			end
			P_R_REL: if (delay_expired()) seq_phase = P_R_WS;
			P_R_WS: if (!c.clk_in) begin
				seq_delay = seq_regs.start_settle_ticks;
				seq_phase = P_R_SET;
			end
			P_R_SET: if (delay_expired()) seq_phase = P_R_WSH;
			P_R_WSH: if (c.clk_in) seq_phase = P_R_BL;
			P_R_BL: if (!c.clk_in) begin
				if (c.data_in)
					seq_shift[seq_bits[2:0]] = 1'b1;
				seq_phase = P_R_BH;
			end
			P_R_BH: if (c.clk_in) begin
				seq_bits = seq_bits + 1'b1;
				seq_phase = (seq_bits < BITS_PER_BYTE) ? P_R_BL : P_R_T1;
			end
			P_R_T1: if (!c.clk_in) seq_phase = P_R_T2;
			P_R_T2: if (c.clk_in) seq_phase = P_R_T3;
			P_R_T3: if (!c.clk_in) seq_phase = P_R_T4;
			P_R_T4: if (c.clk_in) begin
				seq_clk_low = 1'b1;
				seq_rx_last = seq_shift;
				rxv = 1'b1;
				seq_phase = P_IDLE_INH;
			end
			default: begin
				seq_phase = P_IDLE_REL;
				seq_clk_low = 1'b0;
				seq_dat_low = 1'b0;
			end
		endcase
		r.clk_pull_low = seq_clk_low;
		r.data_pull_low = seq_dat_low;
		r.busy_res = seq_busy();
		r.rx_valid = rxv;
		r.rx_byte = seq_rx_last;
		r.tx_done = txd;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_ticks();
		int r;
		r = $urandom_range(0, 19);
		if (r < 7)
			return '0;
		if (r < 18)
			return CFG_DATA_W'($urandom_range(1, 4));
		return CFG_DATA_W'($urandom_range(5, 24));
	endfunction

	task automatic push_tick(input logic [1:0] kind, input logic [7:0] txb, input logic lc,
		input logic ld);
		int g;
		cmd_t c;
		res_t r;
		g = idle_en ? gap_len() : 0;
		if (g != 0) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd.valid <= 1'b1;
		cmd.kind <= kind;
		cmd.tx_byte <= txb;
		cmd.clk_in <= lc;
		cmd.data_in <= ld;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		c.kind = kind;
		c.tx_byte = txb;
		c.clk_in = lc;
		c.data_in = ld;
		seq_step(c, r);
		tick_res_q.push_back(r);
		n_items++;
	endtask

	// device clock toggles with random half periods; data is set on each toggle by the line mode
	task automatic dev_tick(input logic [1:0] kind, input logic [7:0] txb);
		if (dev_half == 0) begin
			dev_clk = ~dev_clk;
			case (dev_mode)
				LINE_LOW: dev_dat = 1'b0;
				LINE_HIGH: dev_dat = 1'b1;
				default: dev_dat = 1'($urandom_range(0, 1));
			endcase
			dev_half = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
		end else
			dev_half--;
		push_tick(kind, txb, dev_clk, dev_dat);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (tick_res_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			CFG_IDLE_RELEASE: seq_regs.idle_release_ticks = val;
			CFG_INHIBIT: seq_regs.inhibit_ticks = val;
			CFG_DATA_LEAD: seq_regs.data_lead_ticks = val;
			CFG_LISTEN_RELEASE: seq_regs.listen_release_ticks = val;
			CFG_START_SETTLE: seq_regs.start_settle_ticks = val;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [CFG_DATA_W-1:0] idle_rel,
		input logic [CFG_DATA_W-1:0] inhibit, input logic [CFG_DATA_W-1:0] lead,
		input logic [CFG_DATA_W-1:0] listen, input logic [CFG_DATA_W-1:0] settle);
		wait_drained();
		write_reg(CFG_IDLE_RELEASE, idle_rel);
		write_reg(CFG_INHIBIT, inhibit);
		write_reg(CFG_DATA_LEAD, lead);
		write_reg(CFG_LISTEN_RELEASE, listen);
		write_reg(CFG_START_SETTLE, settle);
	endtask

	// noise: starts while busy, spare kind, and stretches of frozen lines
	task automatic finish_transfer(input int noise_pct);
		int hold;
		while (seq_busy()) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				if ($urandom_range(0, 3) == 0) begin
					hold = $urandom_range(10, 40);
					repeat (hold)
						push_tick(KIND_TICK, 8'($urandom_range(0, 255)), dev_clk, dev_dat);
				end else
					dev_tick(2'($urandom_range(KIND_SEND, KIND_SPARE)),
						8'($urandom_range(0, 255)));
			end else
				dev_tick(KIND_TICK, 8'($urandom_range(0, 255)));
		end
		n_xfers++;
	endtask

	task automatic run_transfer(input logic [1:0] kind, input logic [7:0] txb, input int noise_pct);
		push_tick(kind, txb, dev_clk, dev_dat);
		finish_transfer(noise_pct);
	endtask

	task automatic test_reset_values();
		push_tick(KIND_TICK, 8'h00, 1'b0, 1'b0);
		push_tick(KIND_SPARE, 8'hFF, 1'b1, 1'b1);
		push_tick(KIND_TICK, 8'h5A, 1'b1, 1'b0);
		run_transfer(KIND_RECV, 8'h00, 0);
		run_transfer(KIND_SEND, 8'hA5, 0);
	endtask

	task automatic test_edge_settings();
		write_all_regs('0, '0, '0, '0, '0);
		run_transfer(KIND_SEND, 8'h00, 0);
		run_transfer(KIND_SEND, 8'hFF, 0);
		run_transfer(KIND_SEND, 8'h01, 0);
		dev_mode = LINE_HIGH;
		run_transfer(KIND_RECV, 8'h00, 0);
		dev_mode = LINE_LOW;
		run_transfer(KIND_RECV, 8'hFF, 0);
		dev_mode = LINE_RANDOM;
		run_transfer(KIND_SEND, 8'h80, 0);
		write_all_regs(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
		write_reg(CFG_UNUSED, 16'h0001);
		push_tick(KIND_SPARE, 8'h3C, 1'b0, 1'b1);
		push_tick(KIND_TICK, 8'hC3, 1'b1, 1'b0);
		// long settle count, run without idling to keep it short
		write_all_regs(16'd1, 16'd2, 16'd0, 16'd3, 16'd200);
		idle_en = 1'b0;
		run_transfer(KIND_RECV, 8'h00, 0);
		idle_en = 1'b1;
	endtask

	task automatic test_busy_and_stalls();
		write_all_regs(16'd2, 16'd3, 16'd1, 16'd2, 16'd1);
		run_transfer(KIND_SEND, 8'($urandom_range(0, 255)), 40);
		run_transfer(KIND_RECV, 8'($urandom_range(0, 255)), 40);
		// sender holds off mid transfer until the pipeline is empty
		push_tick(KIND_SEND, 8'($urandom_range(0, 255)), dev_clk, dev_dat);
		repeat (12) dev_tick(KIND_TICK, 8'h00);
		wait_drained();
		finish_transfer(10);
	endtask

	task automatic test_random_traffic();
		int first;
		int xfers_at;
		first = n_items;
		xfers_at = n_xfers;
		while (n_items - first < RANDOM_TICKS || n_xfers - xfers_at < RANDOM_XFERS) begin
			if ($urandom_range(0, 5) == 0)
				write_all_regs(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
			idle_en = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(0, 4))
				dev_tick($urandom_range(0, 1) ? KIND_TICK : KIND_SPARE,
					8'($urandom_range(0, 255)));
			run_transfer($urandom_range(0, 1) ? KIND_SEND : KIND_RECV,
				8'($urandom_range(0, 255)), 3);
		end
		idle_en = 1'b1;
	endtask

	always @(negedge clk) begin : sink_ready
		int g;
		if (!idle_en)
			res.ready <= 1'b1;
		else if (ready_hold != 0)
			ready_hold <= ready_hold - 1;
		else if (res.ready) begin
			g = gap_len();
			if (g == 0)
				ready_hold <= $urandom_range(0, 15);
			else begin
				res.ready <= 1'b0;
				ready_hold <= g - 1;
			end
		end else begin
			res.ready <= 1'b1;
			ready_hold <= $urandom_range(0, 15);
		end
	end

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			got = {res.clk_pull_low, res.data_pull_low, res.busy_res, res.rx_valid, res.rx_byte,
				res.tx_done};
			if (tick_res_q.size() == 0)
				report_error($sformatf("result %0d arrived with none expected", n_checked));
			else begin
				want = tick_res_q.pop_front();
				if (got.clk_pull_low !== want.clk_pull_low)
					report_error($sformatf("result %0d clk_pull_low %b, expected %b", n_checked,
						got.clk_pull_low, want.clk_pull_low));
				if (got.data_pull_low !== want.data_pull_low)
					report_error($sformatf("result %0d data_pull_low %b, expected %b", n_checked,
						got.data_pull_low, want.data_pull_low));
				if (got.busy_res !== want.busy_res)
					report_error($sformatf("result %0d busy_res %b, expected %b", n_checked,
						got.busy_res, want.busy_res));
				if (got.rx_valid !== want.rx_valid)
					report_error($sformatf("result %0d rx_valid %b, expected %b", n_checked,
						got.rx_valid, want.rx_valid));
				if (got.rx_byte !== want.rx_byte)
					report_error($sformatf("result %0d rx_byte %h, expected %h", n_checked,
						got.rx_byte, want.rx_byte));
				if (got.tx_done !== want.tx_done)
					report_error($sformatf("result %0d tx_done %b, expected %b", n_checked,
						got.tx_done, want.tx_done));
				if (want.tx_done)
					n_sent++;
				if (want.rx_valid)
					n_recv++;
			end
			n_checked++;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.kind = KIND_TICK;
		cmd.tx_byte = '0;
		cmd.clk_in = 1'b1;
		cmd.data_in = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = CFG_IDLE_RELEASE;
		cfg.data = '0;
		res.ready = 1'b0;
		ready_hold = 0;
		idle_en = 1'b1;
		dev_clk = 1'b1;
		dev_dat = 1'b1;
		dev_half = 0;
		dev_mode = LINE_RANDOM;
		n_errors = 0;
		n_items = 0;
		n_checked = 0;
		n_sent = 0;
		n_recv = 0;
		n_writes = 0;
		n_xfers = 0;
		seq_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_edge_settings();
		test_busy_and_stalls();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d ticks checked over %0d transfers: %0d bytes sent, %0d bytes received",
			n_checked, n_xfers, n_sent, n_recv);
		$display("%0d register writes, delays from zero to full scale, %0d errors",
			n_writes, n_errors);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
